@@ rtl/mlsc_pkg.sv @@
package mlsc_pkg;

    // Field and datapath widths
    localparam int SEL_W    = 3;
    localparam int STATUS_W = 2;
    localparam int BITS_W   = 8;
    localparam int ERR_W    = 8;
    localparam int SETTLE_W = 16;
    localparam int WT_W     = 64;
    localparam int SUM_W    = 11;
    localparam int CNT_W    = 4;
    localparam int PHASE_W  = 4;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 64;

    // Scan phase codes; channel phases run 1..CHANNELS
    localparam logic [PHASE_W-1:0] PHASE_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd1;
    localparam logic [PHASE_W-1:0] PHASE_DONE  = 4'd9;

    // Ready status codes
    localparam logic [STATUS_W-1:0] STATUS_RELEASED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SCANNING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd2;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd10;
    localparam logic [SETTLE_W-1:0] SETTLE_MAX   = 16'hFFFF;

    // Register select: bit 3 of the byte address, 8-byte stride
    localparam logic REG_SETTLE = 1'b0;
    localparam logic REG_WEIGHT = 1'b1;

    typedef struct packed {
        logic sensor_level;
        logic release_req;
    } in_t;

    typedef struct packed {
        logic [SEL_W-1:0]        channel_select;
        logic [STATUS_W-1:0]     scan_status;
        logic [BITS_W-1:0]       sensor_bits;
        logic signed [ERR_W-1:0] track_error;
        logic                    error_updated;
    } out_t;

endpackage

@@ rtl/mlsc_div.sv @@
module mlsc_div
    import mlsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [ERR_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic [SUM_W-1:0]  mag;
    logic [ERR_W-1:0]  quo_mag;

    // Take the magnitude; truncation toward zero follows from sign-magnitude
    assign mag       = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    // One restoring step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            rem_next  = '0;
            quo_next  = mag;
            dvs_next  = divisor;
            neg_next  = dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_diff[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Restore the sign; the mean of signed bytes fits in a byte
    assign quo_mag  = quo_reg[ERR_W-1:0];
    assign quotient = neg_reg ? ERR_W'(-quo_mag) : ERR_W'(quo_mag);
    assign done     = done_reg;

endmodule

@@ rtl/mux_line_sensor_scan_centroid.sv @@
// An ordinary tick gives its result in the cycle after the input transfer.
// The tick that ends a scan runs a weight accumulate pass of one channel per cycle,
// a check state, an 11-step restoring divider and its hand-off; the divider is
// skipped when no channel saw the line.
// Reset (rst_n, asynchronous, active low) returns to idle, status 0, bits and error 0,
// settle delay 10 and all weights 0.
module mux_line_sensor_scan_centroid
    import mlsc_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_t              out_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ACC  = 5'b00010,
        ST_CHK  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [SETTLE_W-1:0]     settle_reg;
    logic [WT_W-1:0]         weight_reg;
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic [SETTLE_W-1:0]     count_reg, count_next;
    logic                    wait_reg, wait_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [BITS_W-1:0]       bits_reg, bits_next;
    logic signed [ERR_W-1:0] held_reg, held_next;
    logic [SEL_W-1:0]        mux_reg, mux_next;
    logic                    upd_reg, upd_next;
    logic [SEL_W-1:0]        idx_reg, idx_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [STATUS_W-1:0]     status_rel;
    logic [SETTLE_W-1:0]     count_inc;
    logic [SEL_W-1:0]        ch;
    logic [7:0]              wt;
    logic                    cfg_write;
    logic                    div_start;
    logic                    div_done;
    logic signed [ERR_W-1:0] div_quot;

    // Configuration port: write on the access cycle, read back full value
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_RESET;
            weight_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == REG_SETTLE)
                settle_reg <= pwdata[SETTLE_W-1:0];
            else
                weight_reg <= pwdata[WT_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[3] == REG_WEIGHT)
            prdata = weight_reg;
        else
            prdata = {{(DATA_W-SETTLE_W){1'b0}}, settle_reg};
    end

    // Handshake follows the sequencer
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    assign status_rel = in_data.release_req ? STATUS_RELEASED : status_reg;
    assign count_inc  = (count_reg != SETTLE_MAX) ? count_reg + SETTLE_W'(1) : count_reg;
    assign ch         = SEL_W'(phase_reg - PHASE_FIRST);
    assign wt         = weight_reg[{idx_reg, 3'b000} +: 8];
    assign div_start  = (state_reg == ST_CHK) && (cnt_reg != '0);

    // Tick step, then accumulate weights and, if any channel saw the line, divide at scan end
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        wait_next   = wait_reg;
        status_next = status_reg;
        bits_next   = bits_reg;
        held_next   = held_reg;
        mux_next    = mux_reg;
        upd_next    = upd_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    upd_next    = 1'b0;
                    status_next = status_rel;
                    state_next  = ST_OUT;
                    if (phase_reg == PHASE_IDLE)
                    begin
                        if (status_rel == STATUS_RELEASED)
                        begin
                            status_next = STATUS_SCANNING;
                            mux_next    = '0;
                            count_next  = '0;
                            wait_next   = 1'b1;
                            phase_next  = PHASE_FIRST;
                        end
                    end
                    else if (phase_reg >= PHASE_FIRST && phase_reg <= PHASE_W'(CHANNELS))
                    begin
                        count_next = count_inc;
                        if (wait_reg && count_inc >= settle_reg)
                        begin
                            wait_next     = 1'b0;
                            bits_next[ch] = in_data.sensor_level;
                            if (ch != SEL_W'(CHANNELS - 1))
                            begin
                                mux_next   = ch + SEL_W'(1);
                                count_next = '0;
                                wait_next  = 1'b1;
                                phase_next = phase_reg + PHASE_W'(1);
                            end
                            else
                            begin
                                status_next = STATUS_COMPLETE;
                                upd_next    = 1'b1;
                                phase_next  = PHASE_DONE;
                                state_next  = ST_ACC;
                                idx_next    = '0;
                                sum_next    = '0;
                                cnt_next    = '0;
                            end
                        end
                        else if (!wait_reg)
                        begin
                            // restart settling on the current channel
                            mux_next   = ch;
                            count_next = '0;
                            wait_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PHASE_IDLE;
                    end
                end
            end
            ST_ACC:
            begin
                if (bits_reg[idx_reg])
                begin
                    sum_next = sum_reg + {{(SUM_W-8){wt[7]}}, wt};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                idx_next = idx_reg + SEL_W'(1);
                if (idx_reg == SEL_W'(CHANNELS - 1))
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // hold the last error when no channel saw the line
                if (cnt_reg == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    held_next  = div_quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PHASE_IDLE;
            count_reg  <= '0;
            wait_reg   <= 1'b0;
            status_reg <= STATUS_RELEASED;
            bits_reg   <= '0;
            held_reg   <= '0;
            mux_reg    <= '0;
            upd_reg    <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            wait_reg   <= wait_next;
            status_reg <= status_next;
            bits_reg   <= bits_next;
            held_reg   <= held_next;
            mux_reg    <= mux_next;
            upd_reg    <= upd_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        cnt_reg <= cnt_next;
    end

    mlsc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Drive the result from the stepped state
    assign out_data.channel_select = mux_reg;
    assign out_data.scan_status    = status_reg;
    assign out_data.sensor_bits    = bits_reg;
    assign out_data.track_error    = held_reg;
    assign out_data.error_updated  = upd_reg;

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides open at once");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again before result transfer");

    a_update_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error_updated) |-> (out_data.scan_status == STATUS_COMPLETE))
        else $error("error update without complete status");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV))
        else $error("divide state not entered after start");

endmodule
